[rtl/core/bfs_graph_search_engine_assert.svh]
// Assertion macros for the graph search engine.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef BFS_GRAPH_SEARCH_ENGINE_ASSERT_SVH
`define BFS_GRAPH_SEARCH_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/bfs_pkg.sv]
// Shared types and constants of the graph search engine.
// No dependencies.
package bfs_pkg;
	localparam int DEF_MAX_VERTICES = 32;
	localparam int IDX_W = 5;
	localparam int OP_W = 3;
	localparam int VC_W = 6;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [VC_W-1:0] VC_RESET = 6'd32;
	localparam logic REG_VERTEX_COUNT = 1'b0;

	localparam logic [OP_W-1:0] OP_ADD_EDGE  = 3'd0;
	localparam logic [OP_W-1:0] OP_CLR_ALL   = 3'd1;
	localparam logic [OP_W-1:0] OP_CLR_VERT  = 3'd2;
	localparam logic [OP_W-1:0] OP_BFS       = 3'd3;
	localparam logic [OP_W-1:0] OP_REACH     = 3'd4;
	localparam logic [OP_W-1:0] OP_PATH      = 3'd5;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_all;
	} adj_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] vertex;
		logic [IDX_W-1:0] parent;
		logic is_root;
		logic found;
		logic error;
		logic last;
	} res_t;
endpackage

[rtl/core/bfs_adj_mem.sv]
// Adjacency matrix store: one row per vertex, registered read, row valid bits.
// Depends on bfs_pkg.
module bfs_adj_mem
	import bfs_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic clk,
	input  logic arst_n,
	input  adj_cmd_t cmd,
	input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
	input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
	input  logic [MAX_VERTICES-1:0] wr_row,
	output logic [MAX_VERTICES-1:0] rd_row
);
	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_vld_q;
	logic [MAX_VERTICES-1:0] data_s1;
	logic vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (cmd.rd_en) begin
			data_s1 <= mem[rd_addr];
			vld_s1 <= row_vld_q[rd_addr];
		end
	end

	// A row never written since reset or the last clear reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (cmd.clr_all) begin
			row_vld_q <= '0;
		end else if (cmd.wr_en) begin
			row_vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_row = vld_s1 ? data_s1 : '0;
endmodule

[rtl/core/bfs_ctrl.sv]
// Command sequencer: edge updates, breadth-first search, path walk, result emission.
// Depends on bfs_pkg; drives bfs_adj_mem through its command struct.
module bfs_ctrl
	import bfs_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [OP_W-1:0] opcode,
	input  logic [IDX_W-1:0] src,
	input  logic [IDX_W-1:0] dst,
	input  logic [VC_W-1:0] n_eff,
	output logic busy,
	output logic res_vld,
	output res_t res,
	output adj_cmd_t adj_cmd,
	output logic [$clog2(MAX_VERTICES)-1:0] adj_rd_addr,
	output logic [$clog2(MAX_VERTICES)-1:0] adj_wr_addr,
	output logic [MAX_VERTICES-1:0] adj_wr_row,
	input  logic [MAX_VERTICES-1:0] adj_rd_row
);
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [MAX_VERTICES-1:0] ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_ADD_RD    = 4'd1;
	localparam logic [3:0] S_CLR_RD    = 4'd2;
	localparam logic [3:0] S_CLR_WR    = 4'd3;
	localparam logic [3:0] S_POP       = 4'd4;
	localparam logic [3:0] S_WAIT      = 4'd5;
	localparam logic [3:0] S_SCAN      = 4'd6;
	localparam logic [3:0] S_WALK      = 4'd7;
	localparam logic [3:0] S_EMIT_BFS  = 4'd8;
	localparam logic [3:0] S_EMIT_PATH = 4'd9;

	logic [3:0] state_q;
	logic [OP_W-1:0] op_q;
	logic [VW-1:0] s_q, t_q, x_q;
	logic [CW-1:0] head_q, tail_q, len_q, i_q;
	logic [MAX_VERTICES-1:0] nb_q, visited_q;
	logic [VW-1:0] queue_q [MAX_VERTICES];
	logic [VW-1:0] pred_q [MAX_VERTICES];

	logic accept, src_bad, dst_bad, bad;
	logic [VW-1:0] s_idx;
	logic [MAX_VERTICES-1:0] mask, low_oh;
	logic [VW-1:0] y_idx;
	logic q_we, p_we;
	logic [VW-1:0] q_wa, q_wd, p_wa, p_wd, q_ra, p_ra, q_rd, p_rd;
	logic t_seen;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign s_idx = src[VW-1:0];
	assign src_bad = ({1'b0, src} >= n_eff);
	assign dst_bad = ({1'b0, dst} >= n_eff);
	assign t_seen = visited_q[t_q];

	always_comb begin
		priority case (opcode)
			OP_ADD_EDGE, OP_REACH, OP_PATH: bad = src_bad || dst_bad;
			OP_CLR_VERT, OP_BFS: bad = src_bad;
			default: bad = 1'b0;
		endcase
	end

	always_comb begin
		mask = '0;
		y_idx = '0;
		low_oh = nb_q & (~nb_q + ONE);
		for (int k = 0; k < MAX_VERTICES; k++) begin
			mask[k] = (VC_W'(k) < n_eff);
			if (low_oh[k]) begin
				y_idx = y_idx | VW'(k);
			end
		end
	end

	// Single read port on each of the queue and predecessor arrays.
	always_comb begin
		q_ra = head_q[VW-1:0];
		if (state_q == S_EMIT_BFS || state_q == S_EMIT_PATH) begin
			q_ra = i_q[VW-1:0];
		end
		q_rd = queue_q[q_ra];
		p_ra = (state_q == S_WALK) ? x_q : q_rd;
		p_rd = pred_q[p_ra];
	end

	always_comb begin
		adj_cmd = '0;
		adj_rd_addr = '0;
		adj_wr_addr = '0;
		adj_wr_row = '0;
		q_we = 1'b0;
		q_wa = '0;
		q_wd = '0;
		p_we = 1'b0;
		p_wa = '0;
		p_wd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !bad) begin
					if (opcode == OP_ADD_EDGE) begin
						adj_cmd.rd_en = 1'b1;
						adj_rd_addr = s_idx;
					end else if (opcode == OP_CLR_ALL) begin
						adj_cmd.clr_all = 1'b1;
					end else if (opcode == OP_BFS || opcode == OP_REACH ||
						opcode == OP_PATH) begin
						q_we = 1'b1;
						q_wd = s_idx;
						p_we = 1'b1;
						p_wa = s_idx;
						p_wd = s_idx;
					end
				end
			end
			S_ADD_RD: begin
				adj_cmd.wr_en = 1'b1;
				adj_wr_addr = s_q;
				adj_wr_row = adj_rd_row | (ONE << t_q);
			end
			S_CLR_RD: begin
				adj_cmd.rd_en = 1'b1;
				adj_rd_addr = i_q[VW-1:0];
			end
			S_CLR_WR: begin
				adj_cmd.wr_en = 1'b1;
				adj_wr_addr = i_q[VW-1:0];
				adj_wr_row = (i_q[VW-1:0] == s_q) ? '0 : (adj_rd_row & ~(ONE << s_q));
			end
			S_POP: begin
				if (head_q < tail_q) begin
					adj_cmd.rd_en = 1'b1;
					adj_rd_addr = q_rd;
				end else if (op_q == OP_PATH && t_seen) begin
					q_we = 1'b1;
					q_wd = t_q;
				end
			end
			S_SCAN: begin
				if (nb_q != '0) begin
					q_we = 1'b1;
					q_wa = tail_q[VW-1:0];
					q_wd = y_idx;
					p_we = 1'b1;
					p_wa = y_idx;
					p_wd = x_q;
				end
			end
			S_WALK: begin
				if (x_q != s_q) begin
					q_we = 1'b1;
					q_wa = len_q[VW-1:0];
					q_wd = p_rd;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_q[q_wa] <= q_wd;
		end
		if (p_we) begin
			pred_q[p_wa] <= p_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			s_q <= '0;
			t_q <= '0;
			x_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			len_q <= '0;
			i_q <= '0;
			nb_q <= '0;
			visited_q <= '0;
			res_vld <= 1'b0;
			res <= '0;
		end else begin
			res_vld <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= opcode;
						s_q <= s_idx;
						t_q <= dst[VW-1:0];
						if (bad) begin
							res_vld <= 1'b1;
							res <= '{vertex: '0, parent: '0, is_root: 1'b0, found: 1'b0,
								error: 1'b1, last: 1'b1};
						end else begin
							priority case (opcode)
								OP_ADD_EDGE: state_q <= S_ADD_RD;
								OP_CLR_ALL: begin
									res_vld <= 1'b1;
									res <= '{vertex: '0, parent: '0, is_root: 1'b0,
										found: 1'b1, error: 1'b0, last: 1'b1};
								end
								OP_CLR_VERT: begin
									i_q <= '0;
									state_q <= S_CLR_RD;
								end
								OP_BFS, OP_REACH, OP_PATH: begin
									visited_q <= ONE << s_idx;
									head_q <= '0;
									tail_q <= CW'(1);
									state_q <= S_POP;
								end
								default: begin
									res_vld <= 1'b1;
									res <= '{vertex: '0, parent: '0, is_root: 1'b0,
										found: 1'b0, error: 1'b0, last: 1'b1};
								end
							endcase
						end
					end
				end
				S_ADD_RD: begin
					res_vld <= 1'b1;
					res <= '{vertex: '0, parent: '0, is_root: 1'b0, found: 1'b1,
						error: 1'b0, last: 1'b1};
					state_q <= S_IDLE;
				end
				S_CLR_RD: state_q <= S_CLR_WR;
				S_CLR_WR: begin
					if (i_q == CW'(MAX_VERTICES - 1)) begin
						res_vld <= 1'b1;
						res <= '{vertex: '0, parent: '0, is_root: 1'b0, found: 1'b1,
							error: 1'b0, last: 1'b1};
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_CLR_RD;
					end
				end
				S_POP: begin
					if (head_q < tail_q) begin
						x_q <= q_rd;
						head_q <= head_q + 1'b1;
						state_q <= S_WAIT;
					end else if (op_q == OP_BFS) begin
						i_q <= '0;
						state_q <= S_EMIT_BFS;
					end else if (op_q == OP_REACH) begin
						res_vld <= 1'b1;
						res <= '{vertex: IDX_W'(t_q), parent: '0, is_root: 1'b0,
							found: t_seen, error: 1'b0, last: 1'b1};
						state_q <= S_IDLE;
					end else if (t_seen) begin
						x_q <= t_q;
						len_q <= CW'(1);
						state_q <= S_WALK;
					end else begin
						res_vld <= 1'b1;
						res <= '{vertex: '0, parent: '0, is_root: 1'b0, found: 1'b0,
							error: 1'b0, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_WAIT: begin
					nb_q <= adj_rd_row & mask & ~visited_q;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// One newly reached neighbor per cycle, lowest index first.
					if (nb_q == '0) begin
						state_q <= S_POP;
					end else begin
						visited_q <= visited_q | low_oh;
						nb_q <= nb_q & ~low_oh;
						tail_q <= tail_q + 1'b1;
					end
				end
				S_WALK: begin
					if (x_q == s_q) begin
						i_q <= len_q - 1'b1;
						state_q <= S_EMIT_PATH;
					end else begin
						x_q <= p_rd;
						len_q <= len_q + 1'b1;
					end
				end
				S_EMIT_BFS: begin
					res_vld <= 1'b1;
					res <= '{vertex: IDX_W'(q_rd),
						parent: (i_q == '0) ? '0 : IDX_W'(p_rd),
						is_root: (i_q == '0), found: 1'b1, error: 1'b0,
						last: (i_q + 1'b1 == tail_q)};
					if (i_q + 1'b1 == tail_q) begin
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_EMIT_PATH: begin
					// The path sits reversed in the queue, so it is read from the top down.
					res_vld <= 1'b1;
					res <= '{vertex: IDX_W'(q_rd),
						parent: (i_q == len_q - 1'b1) ? '0 : IDX_W'(p_rd),
						is_root: (i_q == len_q - 1'b1), found: 1'b1, error: 1'b0,
						last: (i_q == '0)};
					if (i_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q - 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/core/bfs_graph_search_engine.sv]
// Graph search engine top level: register port, result ports, checks.
// Depends on bfs_pkg, bfs_ctrl, bfs_adj_mem and the assertion macro header.
//
// Breadth-first search engine over a directed graph stored as an adjacency
// bit matrix, one row per vertex in a memory with a registered read and its
// own write port. A command is taken when start is high and busy is low.
// Results come one per cycle on the result ports, each marked by valid for
// exactly one cycle, and must be taken as they come; last marks the final
// result of a command. Adding an edge reads the source row and writes it back
// with the new bit; clearing all edges drops all row valid bits; clearing one
// vertex reads and writes each matrix row. A search reads the row of each reached
// vertex and scans its new neighbors one per cycle; BFS order then emits the queue,
// a shortest path walks back through the predecessors and emits it root first.
// Unused opcodes answer on the cycle after acceptance without raising busy.
`include "bfs_graph_search_engine_assert.svh"

module bfs_graph_search_engine
	import bfs_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready,
	input  logic start,
	input  logic [OP_W-1:0] opcode,
	input  logic [IDX_W-1:0] src,
	input  logic [IDX_W-1:0] dst,
	output logic busy,
	output logic valid,
	output logic [IDX_W-1:0] vertex,
	output logic [IDX_W-1:0] parent,
	output logic is_root,
	output logic found,
	output logic error,
	output logic last
);
	localparam int VW = $clog2(MAX_VERTICES);

	logic [VC_W-1:0] vc_q;
	logic [VC_W-1:0] n_eff;
	res_t res;
	adj_cmd_t adj_cmd;
	logic [VW-1:0] adj_rd_addr, adj_wr_addr;
	logic [MAX_VERTICES-1:0] adj_wr_row, adj_rd_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VC_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
			vc_q <= pwdata[VC_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? APB_DATA_W'(vc_q) : '0;
	assign n_eff = (vc_q > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vc_q;

	bfs_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.opcode(opcode),
		.src(src),
		.dst(dst),
		.n_eff(n_eff),
		.busy(busy),
		.res_vld(valid),
		.res(res),
		.adj_cmd(adj_cmd),
		.adj_rd_addr(adj_rd_addr),
		.adj_wr_addr(adj_wr_addr),
		.adj_wr_row(adj_wr_row),
		.adj_rd_row(adj_rd_row)
	);

	bfs_adj_mem #(.MAX_VERTICES(MAX_VERTICES)) u_adj (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(adj_cmd),
		.rd_addr(adj_rd_addr),
		.wr_addr(adj_wr_addr),
		.wr_row(adj_wr_row),
		.rd_row(adj_rd_row)
	);

	assign vertex = res.vertex;
	assign parent = res.parent;
	assign is_root = res.is_root;
	assign found = res.found;
	assign error = res.error;
	assign last = res.last;

	`BFS_ASSERT_NEXT(a_accept_answered, start && !busy, busy || valid, "accepted command neither busy nor answered")
	`BFS_ASSERT_NOW(a_idle_means_last, valid && !busy, last, "result after command end without last")
	`BFS_ASSERT_NOW(a_error_alone, valid && error, !found && last && !is_root, "error result carries other flags")
	`BFS_ASSERT_NOW(a_root_found, valid && is_root, found && !error, "root result not marked found")
endmodule
